>>> design/ckph_pkg.sv
// Shared types and fixed constants of the canonical k-mer prefix histogram.
package ckph_pkg;

  localparam int unsigned BaseW        = 2;
  localparam int unsigned CfgW         = 8;
  localparam int unsigned BucketOutW   = 16;
  localparam int unsigned CountOutW    = 32;
  localparam int unsigned EdgeLenReset = 32;
  localparam int unsigned MinEdgeLen   = 2;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic             read_start;
  } ckph_in_t;

  typedef struct packed {
    logic [BucketOutW-1:0] bucket;
    logic [CountOutW-1:0]  bucket_count;
    logic                  from_reverse;
  } ckph_out_t;

endpackage

>>> design/canonical_kmer_prefix_histogram.sv
// Top level of the canonical k-mer prefix histogram.
//
// Takes one base per cycle while in_ready_o is high. A base whose read has
// reached edge_length bases gives one output word: the base is registered
// into the windows; the forward and reverse-complement windows are compared
// and the counter memory read at the chosen bucket into a register; the count
// is incremented, written back and registered as the output word, with the
// written value forwarded when the next word hits the same bucket. After reset
// it clears the 2^(2*PrefixBases) counters (65536 at the default), one a cycle,
// before taking the first base; configuration writes are taken at any time.
module canonical_kmer_prefix_histogram #(
  parameter int unsigned MaxEdgeBases = 128,
  parameter int unsigned PrefixBases  = 8,
  parameter int unsigned CountBits    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ckph_pkg::ckph_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ckph_pkg::ckph_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ckph_pkg::CfgW-1:0] cfg_data_i
);
  import ckph_pkg::*;

  localparam int unsigned LenW    = $clog2(MaxEdgeBases + 1);
  localparam int unsigned WinW    = 2 * MaxEdgeBases;
  localparam int unsigned BucketW = 2 * PrefixBases;
  localparam int unsigned Depth   = 1 << BucketW;
  localparam int unsigned LenReset =
    (EdgeLenReset > MaxEdgeBases) ? MaxEdgeBases : EdgeLenReset;
  localparam logic [CfgW:0] MaxLenC = (CfgW + 1)'(MaxEdgeBases);
  localparam logic [CfgW:0] MinLenC = (CfgW + 1)'(MinEdgeLen);

  typedef logic [CountBits-1:0] count_t;
  typedef logic [BucketW-1:0]   bucket_t;

  logic [LenW-1:0] len_q;
  logic [CfgW:0]   cfg_ext;
  logic [CfgW:0]   cfg_clamp;

  logic [WinW-1:0] fwd_q, fwd_d, rev_q, rev_d, fwd_old, rev_old;
  logic [WinW-1:0] fwd_sh, rev_sh;
  logic [LenW-1:0] bases_q, bases_d, bases_base;
  logic [LenW:0]   len_ext;
  logic            emit;

  logic    valid_a_q, valid_b_q, out_valid_q;
  logic    rev_a, rev_b_q;
  bucket_t bucket_a, bucket_b_q;
  count_t  rd_q, fwd_data_q, old_cnt, new_cnt;
  logic    fwd_hit_q;
  ckph_out_t out_q;

  logic    clr_q;
  bucket_t clr_addr_q;
  count_t  mem [Depth];
  logic    mem_we;
  bucket_t mem_wa;
  count_t  mem_wd;

  logic out_free, b_go, b_free, a_go, a_free, in_go;
  logic [BucketW+BucketOutW-1:0] bucket_wide;
  logic [CountBits+CountOutW-1:0] count_wide;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = {1'b0, cfg_data_i};

  always_comb begin
    if (cfg_ext < MinLenC) begin
      cfg_clamp = MinLenC;
    end else if (cfg_ext > MaxLenC) begin
      cfg_clamp = MaxLenC;
    end else begin
      cfg_clamp = cfg_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(LenReset);
    end else if (cfg_valid_i) begin
      len_q <= LenW'(cfg_clamp);
    end
  end

  // handshake chain
  assign out_free   = !out_valid_q || out_ready_i;
  assign b_go       = valid_b_q && out_free;
  assign b_free     = !valid_b_q || out_free;
  assign a_go       = valid_a_q && b_free;
  assign a_free     = !valid_a_q || b_free;
  assign in_ready_o = a_free && !clr_q;
  assign in_go      = in_valid_i && in_ready_o;

  // window update
  assign len_ext = {1'b0, len_q};
  assign fwd_old = in_data_i.read_start ? '0 : fwd_q;
  assign rev_old = in_data_i.read_start ? '0 : rev_q;
  assign fwd_sh  = fwd_old << 2;
  assign rev_sh  = rev_old >> 2;

  always_comb begin
    fwd_d = '0;
    rev_d = '0;
    for (int i = 0; i < MaxEdgeBases; i++) begin
      if ((LenW + 1)'(i + 1) < len_ext) begin
        fwd_d[2*(MaxEdgeBases-1-i) +: 2] = fwd_sh[2*(MaxEdgeBases-1-i) +: 2];
      end else if ((LenW + 1)'(i + 1) == len_ext) begin
        fwd_d[2*(MaxEdgeBases-1-i) +: 2] = in_data_i.base;
      end
      if (i == 0) begin
        rev_d[2*(MaxEdgeBases-1) +: 2] = ~in_data_i.base;
      end else if ((LenW + 1)'(i) < len_ext) begin
        rev_d[2*(MaxEdgeBases-1-i) +: 2] = rev_sh[2*(MaxEdgeBases-1-i) +: 2];
      end
    end
  end

  assign bases_base = in_data_i.read_start ? '0 : bases_q;

  always_comb begin
    if (bases_base < len_q) begin
      bases_d = bases_base + LenW'(1);
    end else begin
      bases_d = len_q;
    end
  end

  assign emit = (bases_d == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q     <= '0;
      rev_q     <= '0;
      bases_q   <= '0;
      valid_a_q <= 1'b0;
    end else begin
      if (in_go) begin
        fwd_q   <= fwd_d;
        rev_q   <= rev_d;
        bases_q <= bases_d;
      end
      if (a_free) begin
        valid_a_q <= in_go && emit;
      end
    end
  end

  // canonical choice
  assign rev_a    = rev_q < fwd_q;
  assign bucket_a = rev_a ? rev_q[WinW-1 -: BucketW] : fwd_q[WinW-1 -: BucketW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (b_free) begin
      valid_b_q <= a_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      bucket_b_q <= bucket_a;
      rev_b_q    <= rev_a;
      rd_q       <= mem[bucket_a];
      fwd_hit_q  <= b_go && (bucket_b_q == bucket_a);
      fwd_data_q <= new_cnt;
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // increment and write back
  assign old_cnt = fwd_hit_q ? fwd_data_q : rd_q;
  assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + count_t'(1);

  assign mem_we = clr_q || b_go;
  assign mem_wa = clr_q ? clr_addr_q : bucket_b_q;
  assign mem_wd = clr_q ? '0 : new_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + bucket_t'(1);
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // output word
  assign bucket_wide = {{BucketOutW{1'b0}}, bucket_b_q};
  assign count_wide  = {{CountOutW{1'b0}}, new_cnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      out_q.bucket       <= bucket_wide[BucketOutW-1:0];
      out_q.bucket_count <= count_wide[CountOutW-1:0];
      out_q.from_reverse <= rev_b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> dv/ckph_bucket_monitor.sv
// Channel monitor for the k-mer prefix histogram: bucket hit prediction and output compare.
`timescale 1ns / 100ps
module ckph_bucket_monitor
  import ckph_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ckph_in_t        in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ckph_out_t       out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int unsigned     backlog_o,
  output int unsigned     faults_o
);

  localparam int unsigned WinMax   = 128;
  localparam int unsigned PrefixN  = 8;
  localparam bit [31:0]   CountTop = 32'hFFFF_FFFF;

  bit [1:0]        fwd_win [WinMax];
  bit [1:0]        rc_win  [WinMax];
  int unsigned     read_fill;
  logic [CfgW-1:0] edge_len = CfgW'(EdgeLenReset);
  bit [31:0]       bucket_tally [bit [15:0]];
  ckph_out_t       due_hits [$];
  ckph_out_t       want;
  int unsigned     faults;

  task automatic note_fault(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    faults++;
  endtask

  function automatic void count_canonical_prefix(input ckph_in_t item);
    int unsigned win_len;
    int          i;
    bit          rc_less;
    bit          decided;
    bit [15:0]   bkt;
    bit [31:0]   tally;
    ckph_out_t   hit;
    if (edge_len < MinEdgeLen) win_len = MinEdgeLen;
    else if (edge_len > WinMax) win_len = WinMax;
    else win_len = 32'(edge_len);
    if (item.read_start) begin
      read_fill = 0;
      for (i = 0; i < WinMax; i++) begin
        fwd_win[i] = 2'd0;
        rc_win[i]  = 2'd0;
      end
    end
    for (i = 0; i < WinMax - 1; i++) fwd_win[i] = fwd_win[i+1];
    fwd_win[WinMax-1] = 2'd0;
    for (i = win_len; i < WinMax; i++) fwd_win[i] = 2'd0;
    fwd_win[win_len-1] = item.base;
    for (i = WinMax - 1; i > 0; i--) rc_win[i] = rc_win[i-1];
    rc_win[0] = ~item.base;
    for (i = win_len; i < WinMax; i++) rc_win[i] = 2'd0;
    if (read_fill < win_len) read_fill++;
    if (read_fill > win_len) read_fill = win_len;
    if (read_fill < win_len) return;
    rc_less = 1'b0;
    decided = 1'b0;
    for (i = 0; i < WinMax; i++) begin
      if (!decided && rc_win[i] != fwd_win[i]) begin
        rc_less = rc_win[i] < fwd_win[i];
        decided = 1'b1;
      end
    end
    bkt = '0;
    for (i = 0; i < PrefixN; i++) bkt = {bkt[13:0], rc_less ? rc_win[i] : fwd_win[i]};
    tally = bucket_tally.exists(bkt) ? bucket_tally[bkt] : 32'd0;
    if (tally != CountTop) tally++;
    bucket_tally[bkt] = tally;
    hit.bucket       = bkt;
    hit.bucket_count = tally;
    hit.from_reverse = rc_less;
    due_hits.push_back(hit);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) edge_len = cfg_data_i;
      if (in_valid_i && in_ready_i) count_canonical_prefix(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (due_hits.size() == 0) begin
          note_fault($sformatf("unexpected word bucket %h count %0d", out_data_i.bucket,
                               out_data_i.bucket_count));
        end else begin
          want = due_hits.pop_front();
          if (out_data_i.bucket != want.bucket)
            note_fault($sformatf("bucket %h, predicted %h", out_data_i.bucket, want.bucket));
          if (out_data_i.bucket_count != want.bucket_count)
            note_fault($sformatf("bucket %h count %0d, predicted %0d", want.bucket,
                                 out_data_i.bucket_count, want.bucket_count));
          if (out_data_i.from_reverse != want.from_reverse)
            note_fault($sformatf("bucket %h from_reverse %0b, predicted %0b", want.bucket,
                                 out_data_i.from_reverse, want.from_reverse));
        end
      end
    end
    backlog_o <= due_hits.size();
    faults_o  <= faults;
  end

endmodule

>>> dv/tb_canonical_kmer_prefix_histogram.sv
// Testbench top for the canonical k-mer prefix histogram: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_canonical_kmer_prefix_histogram;
  import ckph_pkg::*;

  localparam int unsigned IdleLimit = 300000;
  localparam int unsigned DrainWait = 8;
  localparam int unsigned PlanLen   = 17;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;
  typedef enum int unsigned {ReadWhole, ReadShort, ReadNoise} read_shape_e;
  typedef enum int unsigned {BasesSame, BasesAt, BasesAny} read_content_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_q = 1'b0;
  ckph_in_t        in_word_q = '0;
  logic            in_ready;
  logic            out_valid;
  logic            out_ready_q = 1'b0;
  ckph_out_t       out_word;
  logic            cfg_valid_q = 1'b0;
  logic [CfgW-1:0] cfg_data_q = '0;
  logic            cfg_ready;
  int unsigned     backlog;
  int unsigned     faults;
  int unsigned     burst_left = 0;
  int unsigned     stall_span = 0;
  int unsigned     tick = 0;
  int unsigned     quiet_cycles = 0;
  stall_mode_e     stall_mode = StallNone;

  canonical_kmer_prefix_histogram u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_q),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data_q)
  );

  ckph_bucket_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_i  (in_ready),
    .in_data_i   (in_word_q),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready_q),
    .out_data_i  (out_word),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data_q),
    .backlog_o   (backlog),
    .faults_o    (faults)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_q && in_ready) || (out_valid && out_ready_q) || (cfg_valid_q && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("canonical_kmer_prefix_histogram regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    tick <= tick + 1;
    case (stall_mode)
      StallNone:  out_ready_q <= 1'b1;
      StallLight: out_ready_q <= ($urandom_range(0, 3) != 0);
      StallHeavy: out_ready_q <= ($urandom_range(0, 3) == 0);
      default:    out_ready_q <= (tick[1:0] == 2'd0);
    endcase
  end

  function automatic int unsigned span_of(input logic [CfgW-1:0] len);
    if (len < MinEdgeLen) return MinEdgeLen;
    if (len > 128) return 128;
    return 32'(len);
  endfunction

  function automatic logic [CfgW-1:0] edge_for_phase(input int unsigned p);
    case (p)
      0:  return 8'd0;
      1:  return 8'd1;
      2:  return 8'd255;
      3:  return 8'd3;
      4:  return 8'd5;
      5:  return 8'd8;
      6:  return 8'd9;
      7:  return 8'd16;
      8:  return 8'd31;
      9:  return 8'd33;
      10: return 8'd64;
      11: return 8'd127;
      12: return 8'd128;
      13: return 8'd129;
      14: return 8'd7;
      default: return CfgW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_base(input logic [BaseW-1:0] base_v, input logic start_v);
    if (burst_left == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    in_valid_q <= 1'b1;
    in_word_q  <= {base_v, start_v};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic settle();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_edge(input logic [CfgW-1:0] len);
    cfg_valid_q <= 1'b1;
    cfg_data_q  <= len;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid_q <= 1'b0;
  endtask

  task automatic run_reads(input int unsigned n_items, input int unsigned len,
                           input bit carry_on);
    int unsigned   sent;
    int unsigned   rlen;
    int unsigned   j;
    read_shape_e   shape;
    read_content_e content;
    logic [BaseW-1:0] fixed_base;
    logic [BaseW-1:0] b;
    bit            first_read;
    bit            rs;
    sent = 0;
    first_read = 1'b1;
    while (sent < n_items) begin
      j = $urandom_range(0, 9);
      shape = (j < 8) ? ReadWhole : (j == 8) ? ReadShort : ReadNoise;
      content = read_content_e'($urandom_range(0, 3) > 2 ? 2 : $urandom_range(0, 2));
      fixed_base = BaseW'($urandom_range(0, 3));
      case (shape)
        ReadWhole: rlen = len + $urandom_range(0, 24);
        ReadShort: rlen = $urandom_range(1, len - 1);
        default:   rlen = $urandom_range(1, 6);
      endcase
      for (j = 0; j < rlen; j++) begin
        case (content)
          BasesSame: b = fixed_base;
          BasesAt:   b = $urandom_range(0, 1) ? 2'd3 : 2'd0;
          default:   b = BaseW'($urandom_range(0, 3));
        endcase
        rs = (j == 0) && !(carry_on && first_read);
        if (shape == ReadNoise && $urandom_range(0, 3) == 0) rs = 1'b1;
        send_base(b, rs);
      end
      sent += rlen;
      first_read = 1'b0;
    end
  endtask

  initial begin
    int unsigned     p;
    int unsigned     len;
    logic [CfgW-1:0] edge_v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_reads(EdgeLenReset, EdgeLenReset, 1'b1);
    settle();
    write_edge(CfgW'(MinEdgeLen));
    send_base(2'd0, 1'b1);
    send_base(2'd0, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd1, 1'b1);
    send_base(2'd2, 1'b1);
    send_base(2'd1, 1'b0);
    settle();
    write_edge(8'd16);
    send_base(2'd3, 1'b1);
    repeat (7) send_base(2'd3, 1'b0);
    repeat (8) send_base(2'd0, 1'b0);
    for (p = 0; p < PlanLen; p++) begin
      settle();
      edge_v = edge_for_phase(p);
      write_edge(edge_v);
      len = span_of(edge_v);
      run_reads(len, len, 1'($urandom_range(0, 1)));
    end
    settle();
    if (faults == 0)
      $display("canonical_kmer_prefix_histogram regression: pass");
    else
      $display("canonical_kmer_prefix_histogram regression: fail");
    $finish;
  end

endmodule

>>> canonical_kmer_prefix_histogram.f
design/ckph_pkg.sv
design/canonical_kmer_prefix_histogram.sv
dv/ckph_bucket_monitor.sv
dv/tb_canonical_kmer_prefix_histogram.sv
